>>> sv/wildcard_mask_matcher_assert.svh
// Assertion macros shared by the wildcard mask matcher modules.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef WILDCARD_MASK_MATCHER_ASSERT_SVH
`define WILDCARD_MASK_MATCHER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define WMM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wmm: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define WMM_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wmm: next-cycle check failed");

`endif

>>> sv/wmm_pkg.sv
// Package for the wildcard mask matcher: capacities, byte codes, item types,
// controller states and the command/status structs. No dependencies.
`default_nettype none

package wmm_pkg;

    localparam int MASK_CAPACITY = 128;
    localparam int NAME_CAPACITY = 128;

    localparam int MASK_AW = (MASK_CAPACITY > 1) ? $clog2(MASK_CAPACITY) : 1;
    localparam int NAME_AW = (NAME_CAPACITY > 1) ? $clog2(NAME_CAPACITY) : 1;
    localparam int MASK_LW = $clog2(MASK_CAPACITY + 1);
    localparam int NAME_LW = $clog2(NAME_CAPACITY + 1);

    localparam logic [MASK_LW-1:0] MASK_CAP_L = MASK_LW'(MASK_CAPACITY);
    localparam logic [NAME_LW-1:0] NAME_CAP_L = NAME_LW'(NAME_CAPACITY);

    localparam logic [1:0] KIND_MASK = 2'd0;
    localparam logic [1:0] KIND_NAME = 2'd1;
    localparam logic [1:0] KIND_RUN  = 2'd2;

    localparam logic [7:0] STAR_BYTE   = 8'h2A;
    localparam logic [7:0] QUERY_BYTE  = 8'h3F;
    localparam logic [7:0] ESCAPE_BYTE = 8'h5C;

    localparam logic [15:0] SCORE_MAX = 16'hFFFF;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] ch;
    } wmm_item_t;

    typedef struct packed {
        logic        matched;
        logic [15:0] score;
        logic        overflowed;
    } wmm_result_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_FALL,
        S_STAR,
        S_NEND,
        S_TAIL,
        S_DONE
    } wmm_state_t;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_INIT,
        OP_ADV,
        OP_DEC,
        OP_TAIL_START,
        OP_STEP,
        OP_STEP_WILD,
        OP_BACK
    } wmm_op_t;

    typedef struct packed {
        logic    accept_en;
        wmm_op_t op;
        logic    look_back;
        logic    res_load;
        logic    res_hit;
        logic    finish;
    } wmm_cmd_t;

    typedef struct packed {
        logic run_req;
        logic overflow;
        logic mask_empty;
        logic name_empty;
        logic mask_end;
        logic name_end;
        logic mask_star;
        logic step_hit;
        logic back_ok;
        logic tail_query;
        logic tail_star_ok;
        logic out_ready;
    } wmm_status_t;

endpackage

`default_nettype wire

>>> sv/wildcard_mask_matcher.sv
// Wildcard mask matcher. Items of kind 0 and 1 append a nonzero byte to the
// mask or the name buffer (128 bytes each); a byte that finds its buffer full
// is dropped and flags overflow. A kind 2 item runs the backtracking matcher
// ('*' any run, '?' one byte, backslash escapes, ASCII letters compare without
// case) and yields one result: matched, score (steps plus one, saturating;
// zero on a miss) and overflowed; both buffers are then cleared. A run steps
// through each byte compare (a mismatch restarts behind the last star in the
// same cycle as the compare), each skipped '*', each check at the end of the
// mask or the name, and each mask tail position examined, so its time grows
// with backtracking; the single controller walk over the two byte buffers
// sets this. The run then waits in its done state while an earlier result is
// still stalled at the output. Items stall while a run is in progress.
// Appends are accepted while an earlier result still waits at the output.
// Kind 3 is accepted and ignored. Depends on wmm_pkg, wmm_ctrl and wmm_dp.
`default_nettype none

module wildcard_mask_matcher (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            item_valid,
    output logic                 item_stall,
    input  wmm_pkg::wmm_item_t   item,
    output logic                 result_valid,
    input  wire logic            result_stall,
    output wmm_pkg::wmm_result_t result
);

    wmm_pkg::wmm_cmd_t    cmd;
    wmm_pkg::wmm_status_t status;

    wmm_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    wmm_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cmd          (cmd),
        .status       (status)
    );

endmodule

`default_nettype wire

>>> sv/wmm_ctrl.sv
// Controller for the wildcard mask matcher: sequences one run of the matcher.
// Depends on wmm_pkg and wildcard_mask_matcher_assert.svh.
`default_nettype none
`include "wildcard_mask_matcher_assert.svh"

module wmm_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wmm_pkg::wmm_status_t status,
    output wmm_pkg::wmm_cmd_t    cmd
);

    wmm_pkg::wmm_state_t state_reg;
    wmm_pkg::wmm_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wmm_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            wmm_pkg::S_IDLE:
            begin
                if (status.run_req)
                begin
                    if (status.overflow || status.mask_empty)
                        state_next = wmm_pkg::S_DONE;
                    else
                        state_next = wmm_pkg::S_WALK;
                end
            end
            wmm_pkg::S_WALK:
            begin
                if (status.mask_end)
                    state_next = status.name_end ? wmm_pkg::S_DONE : wmm_pkg::S_TAIL;
                else if (status.name_end)
                    state_next = wmm_pkg::S_NEND;
                else if (status.mask_star)
                    state_next = wmm_pkg::S_STAR;
                else if (status.step_hit || status.back_ok)
                    state_next = wmm_pkg::S_WALK;
                else
                    state_next = wmm_pkg::S_DONE;
            end
            wmm_pkg::S_FALL:
            begin
                if (status.mask_star)
                    state_next = wmm_pkg::S_STAR;
                else if (status.step_hit || status.back_ok)
                    state_next = wmm_pkg::S_WALK;
                else
                    state_next = wmm_pkg::S_DONE;
            end
            wmm_pkg::S_STAR:
            begin
                if (status.mask_star)
                    state_next = wmm_pkg::S_STAR;
                else if (status.step_hit || !status.name_end)
                    state_next = wmm_pkg::S_WALK;
                else
                    state_next = wmm_pkg::S_DONE;
            end
            wmm_pkg::S_NEND:
            begin
                state_next = status.mask_star ? wmm_pkg::S_NEND : wmm_pkg::S_DONE;
            end
            wmm_pkg::S_TAIL:
            begin
                if (status.tail_query)
                    state_next = wmm_pkg::S_TAIL;
                else if (status.tail_star_ok)
                    state_next = wmm_pkg::S_DONE;
                else if (status.back_ok)
                    state_next = wmm_pkg::S_FALL;
                else
                    state_next = wmm_pkg::S_DONE;
            end
            wmm_pkg::S_DONE:
            begin
                if (status.out_ready)
                    state_next = wmm_pkg::S_IDLE;
            end
            default:
            begin
                state_next = wmm_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        cmd.op        = wmm_pkg::OP_HOLD;
        cmd.accept_en = (state_reg == wmm_pkg::S_IDLE);
        // Second mask port looks one byte back while scanning the mask tail.
        cmd.look_back = (state_next == wmm_pkg::S_TAIL);
        unique case (state_reg)
            wmm_pkg::S_IDLE:
            begin
                if (status.run_req)
                begin
                    cmd.op       = wmm_pkg::OP_INIT;
                    cmd.res_load = 1'b1;
                    cmd.res_hit  = !status.overflow && status.mask_empty && status.name_empty;
                end
            end
            wmm_pkg::S_WALK:
            begin
                if (status.mask_end)
                begin
                    if (status.name_end)
                    begin
                        cmd.res_load = 1'b1;
                        cmd.res_hit  = 1'b1;
                    end
                    else
                    begin
                        cmd.op = wmm_pkg::OP_TAIL_START;
                    end
                end
                else if (status.name_end)
                begin
                    cmd.op = wmm_pkg::OP_HOLD;
                end
                else if (status.mask_star)
                begin
                    cmd.op = wmm_pkg::OP_ADV;
                end
                else
                begin
                    cmd.op       = wmm_pkg::OP_STEP;
                    cmd.res_load = !(status.step_hit || status.back_ok);
                end
            end
            wmm_pkg::S_FALL:
            begin
                if (status.mask_star)
                begin
                    cmd.op = wmm_pkg::OP_ADV;
                end
                else
                begin
                    cmd.op       = wmm_pkg::OP_STEP;
                    cmd.res_load = !(status.step_hit || status.back_ok);
                end
            end
            wmm_pkg::S_STAR:
            begin
                if (status.mask_star)
                begin
                    cmd.op = wmm_pkg::OP_ADV;
                end
                else
                begin
                    cmd.op       = wmm_pkg::OP_STEP_WILD;
                    cmd.res_load = !(status.step_hit || !status.name_end);
                end
            end
            wmm_pkg::S_NEND:
            begin
                if (status.mask_star)
                begin
                    cmd.op = wmm_pkg::OP_ADV;
                end
                else
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_hit  = status.mask_end;
                end
            end
            wmm_pkg::S_TAIL:
            begin
                if (status.tail_query)
                begin
                    cmd.op = wmm_pkg::OP_DEC;
                end
                else if (status.tail_star_ok)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_hit  = 1'b1;
                end
                else if (status.back_ok)
                begin
                    cmd.op = wmm_pkg::OP_BACK;
                end
                else
                begin
                    cmd.res_load = 1'b1;
                end
            end
            wmm_pkg::S_DONE:
            begin
                cmd.finish = status.out_ready;
            end
            default:
            begin
                cmd.op = wmm_pkg::OP_HOLD;
            end
        endcase
    end

    // A run with a refused byte never walks the buffers.
    `WMM_ASSERT_IMP(a_no_walk_on_overflow,
        (state_reg != wmm_pkg::S_IDLE) && (state_reg != wmm_pkg::S_DONE),
        !status.overflow)

endmodule

`default_nettype wire

>>> sv/wmm_dp.sv
// Datapath for the wildcard mask matcher: byte buffers, walk pointers,
// step counter and result register. Depends on wmm_pkg and the assert header.
`default_nettype none
`include "wildcard_mask_matcher_assert.svh"

module wmm_dp (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            item_valid,
    output logic                 item_stall,
    input  wmm_pkg::wmm_item_t   item,
    output logic                 result_valid,
    input  wire logic            result_stall,
    output wmm_pkg::wmm_result_t result,
    input  wmm_pkg::wmm_cmd_t    cmd,
    output wmm_pkg::wmm_status_t status
);

    localparam int MLW = wmm_pkg::MASK_LW;
    localparam int NLW = wmm_pkg::NAME_LW;
    localparam int MAW = wmm_pkg::MASK_AW;
    localparam int NAW = wmm_pkg::NAME_AW;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A)
            r = c + 8'h20;
        return r;
    endfunction

    logic [7:0] mask_mem_reg [wmm_pkg::MASK_CAPACITY];
    logic [7:0] name_mem_reg [wmm_pkg::NAME_CAPACITY];
    logic [7:0] mask_qa_reg;
    logic [7:0] mask_qb_reg;
    logic [7:0] name_q_reg;

    logic [MLW-1:0] mask_len_reg, mask_len_next;
    logic [NLW-1:0] name_len_reg, name_len_next;
    logic           ovf_reg, ovf_next;
    logic [MLW-1:0] m_reg, m_next;
    logic [MLW-1:0] ms_reg, ms_next;
    logic [NLW-1:0] n_reg, n_next;
    logic [NLW-1:0] ns_reg, ns_next;
    logic           wild_reg, wild_next;
    logic [15:0]    count_reg, count_next;
    logic           hit_reg, hit_next;
    logic           result_valid_reg, result_valid_next;
    wmm_pkg::wmm_result_t result_reg;

    logic           mask_we, name_we;
    logic           append_ok;
    logic           mask_end, name_end;
    logic [7:0]     mb, nb, nxt, eff;
    logic           esc;
    logic           step_hit;
    logic [MLW-1:0] m_plus1, m_adv;
    logic [NLW-1:0] n_adv;
    logic [MLW-1:0] ms_eff;
    logic [NLW-1:0] ns_eff;
    logic [NLW-1:0] ns_plus1;
    logic [MLW-1:0] m_prev_next, m_succ_next;
    logic [MAW-1:0] mask_addr_a, mask_addr_b;
    logic [15:0]    count_sat, score;

    // Buffer loading
    assign item_stall = !cmd.accept_en;
    assign append_ok  = cmd.accept_en && item_valid && (item.ch != 8'd0);
    assign mask_we    = append_ok && (item.kind == wmm_pkg::KIND_MASK)
                        && (mask_len_reg < wmm_pkg::MASK_CAP_L);
    assign name_we    = append_ok && (item.kind == wmm_pkg::KIND_NAME)
                        && (name_len_reg < wmm_pkg::NAME_CAP_L);

    always_comb
    begin
        mask_len_next = mask_len_reg;
        name_len_next = name_len_reg;
        ovf_next      = ovf_reg;
        if (cmd.finish)
        begin
            mask_len_next = '0;
            name_len_next = '0;
            ovf_next      = 1'b0;
        end
        else
        begin
            if (mask_we)
                mask_len_next = mask_len_reg + MLW'(1);
            if (name_we)
                name_len_next = name_len_reg + NLW'(1);
            // Drop a byte that finds its buffer full and remember it.
            if (append_ok && !mask_we && !name_we
                && ((item.kind == wmm_pkg::KIND_MASK) || (item.kind == wmm_pkg::KIND_NAME)))
                ovf_next = 1'b1;
        end
    end

    // Bytes under the pointers; stored bytes are never zero, so the end reads as zero.
    assign mask_end = (m_reg >= mask_len_reg);
    assign name_end = (n_reg >= name_len_reg);
    assign mb       = mask_end ? 8'd0 : mask_qa_reg;
    assign nb       = name_end ? 8'd0 : name_q_reg;
    assign m_plus1  = m_reg + MLW'(1);
    assign nxt      = (m_plus1 < mask_len_reg) ? mask_qb_reg : 8'd0;
    assign esc      = (mb == wmm_pkg::ESCAPE_BYTE)
                      && ((nxt == wmm_pkg::STAR_BYTE) || (nxt == wmm_pkg::QUERY_BYTE));
    assign eff      = esc ? nxt : mb;
    assign step_hit = (fold_case(eff) == fold_case(nb))
                      || ((eff == wmm_pkg::QUERY_BYTE) && !esc);

    always_comb
    begin
        if (esc)
            m_adv = m_reg + MLW'(2);
        else if (!mask_end)
            m_adv = m_plus1;
        else
            m_adv = m_reg;
    end

    assign n_adv     = name_end ? n_reg : n_reg + NLW'(1);
    assign count_sat = (count_reg == wmm_pkg::SCORE_MAX) ? count_reg : count_reg + 16'd1;
    assign ms_eff    = (cmd.op == wmm_pkg::OP_STEP_WILD) ? m_reg : ms_reg;
    assign ns_eff    = (cmd.op == wmm_pkg::OP_STEP_WILD) ? n_reg : ns_reg;
    assign ns_plus1  = ns_eff + NLW'(1);

    always_comb
    begin
        m_next     = m_reg;
        n_next     = n_reg;
        ms_next    = ms_reg;
        ns_next    = ns_reg;
        wild_next  = wild_reg;
        count_next = count_reg;
        unique case (cmd.op)
            wmm_pkg::OP_HOLD:
            begin
                m_next = m_reg;
            end
            wmm_pkg::OP_INIT:
            begin
                m_next     = '0;
                n_next     = '0;
                ms_next    = '0;
                ns_next    = '0;
                wild_next  = 1'b0;
                count_next = '0;
            end
            wmm_pkg::OP_ADV:
            begin
                m_next = m_plus1;
            end
            wmm_pkg::OP_DEC:
            begin
                m_next = m_reg - MLW'(1);
            end
            wmm_pkg::OP_TAIL_START:
            begin
                m_next = mask_len_reg - MLW'(1);
            end
            wmm_pkg::OP_STEP, wmm_pkg::OP_STEP_WILD:
            begin
                if (cmd.op == wmm_pkg::OP_STEP_WILD)
                begin
                    wild_next = 1'b1;
                    ms_next   = m_reg;
                    ns_next   = n_reg;
                end
                if (step_hit)
                begin
                    m_next     = m_adv;
                    n_next     = n_adv;
                    count_next = count_sat;
                end
                else
                begin
                    // Restart one name byte later behind the last star.
                    m_next  = ms_eff;
                    ns_next = ns_plus1;
                    n_next  = ns_plus1;
                end
            end
            wmm_pkg::OP_BACK:
            begin
                m_next  = ms_reg;
                ns_next = ns_plus1;
                n_next  = ns_plus1;
            end
            default:
            begin
                m_next = m_reg;
            end
        endcase
    end

    assign m_prev_next = m_next - MLW'(1);
    assign m_succ_next = m_next + MLW'(1);
    assign mask_addr_a = m_next[MAW-1:0];
    assign mask_addr_b = cmd.look_back ? m_prev_next[MAW-1:0] : m_succ_next[MAW-1:0];

    // Read at the next pointer values so the data lines up with the pointers.
    always_ff @(posedge clk)
    begin
        if (mask_we)
            mask_mem_reg[mask_len_reg[MAW-1:0]] <= item.ch;
        mask_qa_reg <= mask_mem_reg[mask_addr_a];
        mask_qb_reg <= mask_mem_reg[mask_addr_b];
    end

    always_ff @(posedge clk)
    begin
        if (name_we)
            name_mem_reg[name_len_reg[NAW-1:0]] <= item.ch;
        name_q_reg <= name_mem_reg[n_next[NAW-1:0]];
    end

    // Result register
    assign hit_next          = cmd.res_load ? cmd.res_hit : hit_reg;
    assign score             = !hit_reg ? 16'd0 : count_sat;
    assign result_valid_next = cmd.finish ? 1'b1 : (result_valid_reg && result_stall);

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            result_reg.matched    <= hit_reg;
            result_reg.score      <= score;
            result_reg.overflowed <= ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_len_reg     <= '0;
            name_len_reg     <= '0;
            ovf_reg          <= 1'b0;
            m_reg            <= '0;
            n_reg            <= '0;
            ms_reg           <= '0;
            ns_reg           <= '0;
            wild_reg         <= 1'b0;
            count_reg        <= '0;
            hit_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            mask_len_reg     <= mask_len_next;
            name_len_reg     <= name_len_next;
            ovf_reg          <= ovf_next;
            m_reg            <= m_next;
            n_reg            <= n_next;
            ms_reg           <= ms_next;
            ns_reg           <= ns_next;
            wild_reg         <= wild_next;
            count_reg        <= count_next;
            hit_reg          <= hit_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // The controller only looks at the run request while it is idle.
    always_comb
    begin
        status              = '0;
        status.run_req      = item_valid && (item.kind == wmm_pkg::KIND_RUN);
        status.overflow     = ovf_reg;
        status.mask_empty   = (mask_len_reg == '0);
        status.name_empty   = (name_len_reg == '0);
        status.mask_end     = mask_end;
        status.name_end     = name_end;
        status.mask_star    = (mb == wmm_pkg::STAR_BYTE);
        status.step_hit     = step_hit;
        status.back_ok      = wild_reg && (ns_reg < name_len_reg);
        status.tail_query   = (mask_qa_reg == wmm_pkg::QUERY_BYTE) && (m_reg != '0);
        status.tail_star_ok = (mask_qa_reg == wmm_pkg::STAR_BYTE) && (m_reg != '0)
                              && (mask_qb_reg != wmm_pkg::ESCAPE_BYTE);
        status.out_ready    = !result_valid_reg || !result_stall;
    end

    // Star skipping only moves over stored bytes.
    `WMM_ASSERT_IMP(a_adv_inside_mask, (cmd.op == wmm_pkg::OP_ADV), (m_reg < mask_len_reg))
    // Tail scan never steps below the first mask byte.
    `WMM_ASSERT_IMP(a_dec_above_zero, (cmd.op == wmm_pkg::OP_DEC),
        (m_reg != '0) && (m_reg < mask_len_reg))
    // Delivering a result empties both buffers and the overflow flag.
    `WMM_ASSERT_NXT(a_finish_clears, cmd.finish,
        (mask_len_reg == '0) && (name_len_reg == '0) && !ovf_reg && result_valid_reg)

endmodule

`default_nettype wire

>>> tb/wildcard_mask_matcher_tb.sv
// Testbench for wildcard_mask_matcher: directed and random mask/name loads and match runs,
// checked run by run against a behavioral matcher kept in this file.
// Depends on wmm_pkg and the wildcard_mask_matcher RTL.
`default_nettype none

module wildcard_mask_matcher_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int RESET_CYCLES = 8;
    localparam int STIM_TARGET = 1700;
    localparam int DRAIN_CYCLES = 64;
    // Longest legal silence: a 128x128 run with full backtracking.
    localparam int WATCHDOG_LIMIT = 200000;

    typedef logic [7:0] byte_list_t [$];

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_stall;
    wmm_pkg::wmm_item_t item = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    wmm_pkg::wmm_result_t result;

    wmm_pkg::wmm_item_t item_stream [$];
    wmm_pkg::wmm_result_t verdict_queue [$];

    // Behavioral copy of the two buffers.
    logic [7:0] shadow_mask [wmm_pkg::MASK_CAPACITY];
    logic [7:0] shadow_name [wmm_pkg::NAME_CAPACITY];
    int shadow_mask_len = 0;
    int shadow_name_len = 0;
    bit shadow_overflow = 1'b0;

    int stim_count = 0;
    int accepted_items = 0;
    int mismatch_count = 0;
    int quiet_cycles = 0;
    logic calm;

    wildcard_mask_matcher uut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result)
    );

    always #5ns clk = ~clk;

    // Long stretch with no idling on either side.
    assign calm = (accepted_items >= 700) && (accepted_items < 1000);

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        mismatch_count++;
    endtask

    function automatic logic [7:0] mask_byte_at(input int i);
        return (i >= 0 && i < shadow_mask_len) ? shadow_mask[i] : 8'h00;
    endfunction

    function automatic logic [7:0] name_byte_at(input int i);
        return (i >= 0 && i < shadow_name_len) ? shadow_name[i] : 8'h00;
    endfunction

    function automatic logic [7:0] lower_ascii(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
    endfunction

    // Iterative wildcard walk with a single backtrack point behind the last star.
    function automatic bit glob_match(output int unsigned steps);
        int m, n, ms, ns;
        int unsigned walked;
        bit wild, esc, hit, done;
        m = 0;
        n = 0;
        ms = 0;
        ns = 0;
        walked = 0;
        wild = 1'b0;
        hit = 1'b0;
        done = 1'b0;
        steps = 0;
        if (shadow_mask_len == 0)
            return shadow_name_len == 0;
        while (!done)
        begin
            if (mask_byte_at(m) == 8'h00)
            begin
                if (name_byte_at(n) == 8'h00)
                begin
                    hit = 1'b1;
                    done = 1'b1;
                end
                else
                begin
                    m = shadow_mask_len - 1;
                    while (mask_byte_at(m) == wmm_pkg::QUERY_BYTE && m > 0)
                        m--;
                    if (mask_byte_at(m) == wmm_pkg::STAR_BYTE && m > 0
                        && mask_byte_at(m - 1) != wmm_pkg::ESCAPE_BYTE)
                    begin
                        hit = 1'b1;
                        done = 1'b1;
                    end
                    else if (!wild || ns >= shadow_name_len)
                    begin
                        done = 1'b1;
                    end
                    else
                    begin
                        m = ms;
                        ns++;
                        n = ns;
                    end
                end
            end
            else if (name_byte_at(n) == 8'h00)
            begin
                while (mask_byte_at(m) == wmm_pkg::STAR_BYTE)
                    m++;
                hit = (mask_byte_at(m) == 8'h00);
                done = 1'b1;
            end
            if (!done)
            begin
                if (mask_byte_at(m) == wmm_pkg::STAR_BYTE)
                begin
                    while (mask_byte_at(m) == wmm_pkg::STAR_BYTE)
                        m++;
                    wild = 1'b1;
                    ms = m;
                    ns = n;
                end
                esc = 1'b0;
                if (mask_byte_at(m) == wmm_pkg::ESCAPE_BYTE
                    && (mask_byte_at(m + 1) == wmm_pkg::STAR_BYTE
                    || mask_byte_at(m + 1) == wmm_pkg::QUERY_BYTE))
                begin
                    m++;
                    esc = 1'b1;
                end
                if (lower_ascii(mask_byte_at(m)) != lower_ascii(name_byte_at(n))
                    && (mask_byte_at(m) != wmm_pkg::QUERY_BYTE || esc))
                begin
                    if (!wild || ns >= shadow_name_len)
                    begin
                        done = 1'b1;
                    end
                    else
                    begin
                        m = ms;
                        ns++;
                        n = ns;
                    end
                end
                else
                begin
                    if (walked != 32'hFFFF_FFFF)
                        walked++;
                    if (mask_byte_at(m) != 8'h00)
                        m++;
                    if (name_byte_at(n) != 8'h00)
                        n++;
                end
            end
        end
        if (hit)
            steps = walked;
        return hit;
    endfunction

    // Advance the shadow buffers by one accepted item; a run queues its verdict.
    task automatic apply_item(input wmm_pkg::wmm_item_t it);
        wmm_pkg::wmm_result_t verdict;
        int unsigned steps;
        bit hit;
        steps = 0;
        hit = 1'b0;
        case (it.kind)
            wmm_pkg::KIND_MASK:
            begin
                if (it.ch != 8'h00)
                begin
                    if (shadow_mask_len < wmm_pkg::MASK_CAPACITY)
                    begin
                        shadow_mask[shadow_mask_len] = it.ch;
                        shadow_mask_len++;
                    end
                    else
                    begin
                        shadow_overflow = 1'b1;
                    end
                end
            end
            wmm_pkg::KIND_NAME:
            begin
                if (it.ch != 8'h00)
                begin
                    if (shadow_name_len < wmm_pkg::NAME_CAPACITY)
                    begin
                        shadow_name[shadow_name_len] = it.ch;
                        shadow_name_len++;
                    end
                    else
                    begin
                        shadow_overflow = 1'b1;
                    end
                end
            end
            wmm_pkg::KIND_RUN:
            begin
                if (!shadow_overflow)
                    hit = glob_match(steps);
                verdict.matched = hit;
                if (!hit)
                    verdict.score = 16'h0000;
                else if (steps >= 32'd65535)
                    verdict.score = wmm_pkg::SCORE_MAX;
                else
                    verdict.score = 16'(steps + 1);
                verdict.overflowed = shadow_overflow;
                verdict_queue.push_back(verdict);
                shadow_mask_len = 0;
                shadow_name_len = 0;
                shadow_overflow = 1'b0;
            end
            default: ;
        endcase
    endtask

    task automatic push_item(input logic [1:0] kind, input logic [7:0] ch);
        wmm_pkg::wmm_item_t it;
        it.kind = kind;
        it.ch = ch;
        item_stream.push_back(it);
        if (kind == wmm_pkg::KIND_RUN
            || ((kind == wmm_pkg::KIND_MASK || kind == wmm_pkg::KIND_NAME) && ch != 8'h00))
            stim_count++;
    endtask

    task automatic queue_case(input string mask_text, input string name_text);
        for (int i = 0; i < mask_text.len(); i++)
            push_item(wmm_pkg::KIND_MASK, mask_text[i]);
        for (int i = 0; i < name_text.len(); i++)
            push_item(wmm_pkg::KIND_NAME, name_text[i]);
        push_item(wmm_pkg::KIND_RUN, 8'(($urandom_range(0, 255))));
    endtask

    function automatic logic [7:0] pick_letter();
        return 8'h41 + 8'($urandom_range(0, 25)) + ($urandom_range(0, 1) ? 8'h20 : 8'h00);
    endfunction

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25)
            return ($urandom_range(0, 1) ? 8'h61 : 8'h62) - ($urandom_range(0, 1) ? 8'h20 : 8'h00);
        else if (r < 40)
            return wmm_pkg::STAR_BYTE;
        else if (r < 52)
            return wmm_pkg::QUERY_BYTE;
        else if (r < 60)
            return wmm_pkg::ESCAPE_BYTE;
        else if (r < 75)
            return pick_letter();
        else
            return 8'($urandom_range(1, 255));
    endfunction

    // Build a name that the pattern should accept, with case flips on letters.
    function automatic byte_list_t instance_of(input byte_list_t pattern);
        byte_list_t text;
        logic [7:0] b;
        int i;
        i = 0;
        while (i < pattern.size())
        begin
            b = pattern[i];
            if (b == wmm_pkg::ESCAPE_BYTE && i + 1 < pattern.size()
                && (pattern[i + 1] == wmm_pkg::STAR_BYTE
                || pattern[i + 1] == wmm_pkg::QUERY_BYTE))
            begin
                text.push_back(pattern[i + 1]);
                i++;
            end
            else if (b == wmm_pkg::STAR_BYTE)
            begin
                repeat ($urandom_range(0, 3))
                    text.push_back(pick_byte());
            end
            else if (b == wmm_pkg::QUERY_BYTE)
            begin
                text.push_back(pick_byte());
            end
            else if (lower_ascii(b) >= 8'h61 && lower_ascii(b) <= 8'h7A)
            begin
                text.push_back(b ^ ($urandom_range(0, 1) ? 8'h20 : 8'h00));
            end
            else
            begin
                text.push_back(b);
            end
            i++;
        end
        return text;
    endfunction

    task automatic queue_random_sequence();
        byte_list_t mask_q;
        byte_list_t name_q;
        int mask_n, r, mi, ni;
        r = $urandom_range(0, 99);
        if (r < 85)
            mask_n = $urandom_range(0, 10);
        else if (r < 97)
            mask_n = $urandom_range(11, 40);
        else
            mask_n = $urandom_range(100, 135);
        repeat (mask_n)
            mask_q.push_back(pick_byte());
        r = $urandom_range(0, 99);
        if (r < 85)
        begin
            name_q = instance_of(mask_q);
            if (r >= 70 && name_q.size() > 0)
                name_q[$urandom_range(0, name_q.size() - 1)] = pick_byte();
        end
        else
        begin
            repeat ($urandom_range(0, mask_n + 3))
                name_q.push_back(pick_byte());
        end
        if ($urandom_range(0, 99) < 2)
            while (name_q.size() < wmm_pkg::NAME_CAPACITY + 2)
                name_q.push_back(pick_byte());
        // Interleave the two loads; sprinkle ignored items now and then.
        mi = 0;
        ni = 0;
        while (mi < mask_q.size() || ni < name_q.size())
        begin
            if ($urandom_range(0, 99) < 3)
            begin
                if ($urandom_range(0, 1))
                    push_item(KIND_UNUSED, 8'($urandom_range(0, 255)));
                else
                    push_item($urandom_range(0, 1) ? wmm_pkg::KIND_NAME : wmm_pkg::KIND_MASK,
                        8'h00);
            end
            if (ni >= name_q.size() || (mi < mask_q.size() && $urandom_range(0, 1)))
            begin
                push_item(wmm_pkg::KIND_MASK, mask_q[mi]);
                mi++;
            end
            else
            begin
                push_item(wmm_pkg::KIND_NAME, name_q[ni]);
                ni++;
            end
        end
        // Leave the run out now and then so the loads pile into the next sequence.
        if ($urandom_range(0, 99) < 95)
            push_item(wmm_pkg::KIND_RUN, 8'($urandom_range(0, 255)));
    endtask

    // Item driver; the shadow model advances on each accepted item.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item <= '0;
        end
        else
        begin
            if (item_valid && !item_stall)
            begin
                apply_item(item);
                accepted_items <= accepted_items + 1;
            end
            if (!item_valid || !item_stall)
            begin
                if (item_stream.size() > 0 && (calm || $urandom_range(0, 99) >= 20))
                begin
                    item_valid <= 1'b1;
                    item <= item_stream.pop_front();
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
            result_stall <= !calm && ($urandom_range(0, 99) < 20);
    end

    always @(posedge clk)
    begin : result_check
        wmm_pkg::wmm_result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (verdict_queue.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result m=%0b s=%0d o=%0b",
                    result.matched, result.score, result.overflowed));
            end
            else
            begin
                want = verdict_queue.pop_front();
                if (result.matched !== want.matched)
                    report_mismatch($sformatf("matched %b, want %b",
                        result.matched, want.matched));
                if (result.score !== want.score)
                    report_mismatch($sformatf("score %0d, want %0d",
                        result.score, want.score));
                if (result.overflowed !== want.overflowed)
                    report_mismatch($sformatf("overflowed %b, want %b",
                        result.overflowed, want.overflowed));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (rst_n);
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("wildcard_mask_matcher_tb: errors");
        $finish;
    end

    initial
    begin
        // Directed: empty buffers, ignored items, extremes, escapes, case, tail rule.
        push_item(wmm_pkg::KIND_RUN, 8'hFF);
        push_item(KIND_UNUSED, 8'hA5);
        push_item(wmm_pkg::KIND_MASK, 8'h00);
        push_item(wmm_pkg::KIND_NAME, 8'h00);
        queue_case("", "b");
        queue_case("A\\*?", "a*x");
        queue_case("x*?", "xy");
        queue_case("\377*\001", "\377q\001");
        queue_case("*b", "a");
        queue_case("ab", "");
        while (stim_count < STIM_TARGET)
            queue_random_sequence();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        @(posedge clk);
        while (item_stream.size() > 0 || item_valid)
            @(posedge clk);
        while (verdict_queue.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("wildcard_mask_matcher_tb: clean");
        else
            $display("wildcard_mask_matcher_tb: errors");
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
+incdir+sv
sv/wmm_pkg.sv
sv/wmm_ctrl.sv
sv/wmm_dp.sv
sv/wildcard_mask_matcher.sv
tb/wildcard_mask_matcher_tb.sv
